/* design/dfq_pkg.sv */
// Package for the deduplicating queue with remove by identifier.
// Holds the word types, operation and status codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package dfq_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 16;

  // Fixed field widths of the channel words.
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdFieldW = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 5;

  // Operation codes; the high bit alone selects pop.
  localparam logic [OpW-1:0] OP_ENTER  = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam int unsigned    OP_POP_BIT = 1;

  typedef enum logic [StatusW-1:0] {
    ST_APPENDED  = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_POPPED    = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]      operation;
    logic [IdFieldW-1:0] vehicle_id;
  } in_word_t;

  typedef struct packed {
    status_e             status;
    logic [IdFieldW-1:0] result_id;
    logic [PosW-1:0]     position;
    logic [CountW-1:0]   entry_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic walk;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/dfq_ram.sv */
// Generic simple dual port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps

module dfq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dfq_ctrl.sv */
// Controller state machine of the queue: accepts a word, runs the walk
// over the stored entries and hands the result to the output register.
// Depends on dfq_pkg.
`timescale 1ns / 1ps

module dfq_ctrl
  import dfq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  logic   accept;

  assign accept = in_valid_i && !stall_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and the registered stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != S_IDLE);
    end
  end

  assign in_stall_o = stall_q;

endmodule

/* design/dfq_datapath.sv */
// Datapath of the queue: entry memory, walk counters, match and shift
// logic, occupancy and the output register.
// Depends on dfq_pkg and dfq_ram.
`timescale 1ns / 1ps

module dfq_datapath
  import dfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned ID_BITS     = IdBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned IdW  = (ID_BITS < IdFieldW) ? ID_BITS : IdFieldW;
  localparam int unsigned AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned OccW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OccW-1:0] OccFull = OccW'(QUEUE_DEPTH);

  logic [OpW-1:0]  op_q;
  logic [IdW-1:0]  id_q;
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] rd_q;
  logic            dv_q;
  logic [AW-1:0]   cmp_q;
  logic            found_q;
  logic [AW-1:0]   pos_q;
  logic [IdW-1:0]  rid_q;
  logic            out_valid_q;
  out_word_t       out_q, out_d;

  logic            is_pop;
  logic            more;
  logic            match;
  logic [IdW-1:0]  rdata;
  logic            shift_we;
  logic            append_we;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [IdW-1:0]  ram_wdata;

  assign is_pop = op_q[OP_POP_BIT];
  assign more   = (rd_q < occ_q);

  // A pop matches the head; enter and remove compare identifiers.
  assign match = dv_q && !found_q && (is_pop ? (cmp_q == '0) : (rdata == id_q));

  // After the match every later entry of a remove or pop moves down by one.
  assign shift_we  = cmd_i.walk && dv_q && found_q && (op_q != OP_REMOVE ? is_pop : 1'b1);

  assign stat_o.walk_done = !dv_q && !more;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // Result and occupancy at the end of the walk.
  always_comb begin
    out_d             = '0;
    out_d.result_id   = IdFieldW'(id_q);
    occ_d             = occ_q;
    append_we         = 1'b0;
    if (is_pop) begin
      if (found_q) begin
        out_d.status    = ST_POPPED;
        out_d.result_id = IdFieldW'(rid_q);
        occ_d           = occ_q - 1'b1;
      end else begin
        out_d.status = ST_EMPTY;
      end
    end else if (op_q == OP_REMOVE) begin
      if (found_q) begin
        out_d.status   = ST_REMOVED;
        out_d.position = PosW'(pos_q);
        occ_d          = occ_q - 1'b1;
      end else begin
        out_d.status = ST_NOT_FOUND;
      end
    end else begin
      if (found_q) begin
        out_d.status   = ST_ALREADY;
        out_d.position = PosW'(pos_q);
      end else if (occ_q == OccFull) begin
        out_d.status = ST_FULL;
      end else begin
        out_d.status   = ST_APPENDED;
        out_d.position = PosW'(occ_q);
        occ_d          = occ_q + 1'b1;
        append_we      = cmd_i.finish;
      end
    end
    out_d.entry_count = CountW'(occ_d);
  end

  // One write port serves the shift and the append.
  assign ram_we    = shift_we || append_we;
  assign ram_waddr = append_we ? occ_q[AW-1:0] : (cmp_q - 1'b1);
  assign ram_wdata = append_we ? id_q : rdata;

  dfq_ram #(
    .WIDTH (IdW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Walk state and the latched request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      rd_q    <= '0;
      dv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        rd_q    <= '0;
        dv_q    <= 1'b0;
        found_q <= 1'b0;
      end else if (cmd_i.walk) begin
        rd_q <= rd_q + OccW'(more);
        dv_q <= more;
        if (match) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        occ_q <= occ_d;
      end
    end
  end

  // Payload registers of the walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= in_word_i.operation;
      id_q  <= in_word_i.vehicle_id[IdW-1:0];
      pos_q <= '0;
    end else if (cmd_i.walk) begin
      cmp_q <= rd_q[AW-1:0];
      if (match) begin
        pos_q <= cmp_q;
        rid_q <= rdata;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* design/dedup_fifo_with_remove_by_id_core.sv */
// Deduplicating ordered queue of identifiers with remove by identifier.
// Top level: controller and datapath. Depends on dfq_pkg, dfq_ctrl and
// dfq_datapath.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_word_i) takes one word
//   with an operation: enter if absent, remove by identifier, or pop head.
//   The output channel (out_valid_o, out_stall_i, out_word_o) gives one
//   word per input: status, identifier, position and entry count.
//   Each operation walks the stored entries, one memory read per cycle;
//   a match is recorded and, for remove and pop, every later entry is
//   written one place down in the same pass.
//   The result is registered once the walk has read all N stored entries,
//   where N is the entry count at acceptance. The input stays stalled
//   until the result is in the output register, so the walk over the
//   single memory read port sets the throughput.
//   A finished result waits in the output register; a new word is
//   accepted meanwhile and its walk runs, but it completes only once the
//   receiver has taken the earlier result.
//   Reset empties the queue; memory entries are only used once written.
`timescale 1ns / 1ps

module dedup_fifo_with_remove_by_id_core
  import dfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned ID_BITS     = IdBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencing of each operation.
  dfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Entry storage, walk and result.
  dfq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* design/dfq_checker.sv */
// Port level checks of the queue and the bind that attaches them.
// Depends on dfq_pkg and dedup_fifo_with_remove_by_id_core.
`timescale 1ns / 1ps

module dfq_checker
  import dfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // An accepted word raises the input stall.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // The entry count never exceeds the depth.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (QUEUE_DEPTH > 31) ||
      (out_word_o.entry_count <= CountW'(QUEUE_DEPTH)))
    else $error("entry count above depth");

  // An appended word lands at the tail.
  a_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_APPENDED |->
      out_word_o.position == PosW'(out_word_o.entry_count - 1'b1))
    else $error("append position is not the tail");

  // Pop, empty, full and not found results carry position zero.
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_POPPED || out_word_o.status == ST_EMPTY ||
      out_word_o.status == ST_FULL || out_word_o.status == ST_NOT_FOUND) |->
      out_word_o.position == '0)
    else $error("nonzero position for pop, empty, full or not found");

endmodule

bind dedup_fifo_with_remove_by_id_core dfq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dfq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

/* verif/tb.sv */
// Testbench for dedup_fifo_with_remove_by_id_core: directed and random words with a
// queue predictor, checking each output word. Depends on dfq_pkg and the core.
`timescale 1ns / 1ps

module tb;
  import dfq_pkg::*;

  // The package names no pop code, because any code with the high bit set pops.
  localparam logic [OpW-1:0] OP_POP     = 2'd2;
  localparam logic [OpW-1:0] OP_POP_ALT = 2'd3;
  localparam int unsigned    POOL_SIZE  = 24;
  localparam logic [IdFieldW-1:0] ID_MASK = IdFieldW'((64'd1 << IdBitsDef) - 1);

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // Predictor state and the words still awaited from the core.
  logic [IdFieldW-1:0] queued_ids_q[$];
  out_word_t           pending_words[$];
  logic [IdFieldW-1:0] id_pool[POOL_SIZE];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int status_seen[8];

  dedup_fifo_with_remove_by_id_core #(
    .QUEUE_DEPTH(QueueDepthDef),
    .ID_BITS    (IdBitsDef)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver stall pattern for the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Applies one operation to the predicted queue and returns the word it yields.
  function automatic out_word_t apply_queue_op(in_word_t w);
    out_word_t           res;
    logic [IdFieldW-1:0] id;
    int                  idx;
    id = w.vehicle_id & ID_MASK;
    idx = -1;
    res.result_id = id;
    res.position = '0;
    if (!w.operation[OP_POP_BIT]) begin
      foreach (queued_ids_q[i]) begin
        if (idx < 0 && queued_ids_q[i] == id) idx = i;
      end
    end
    if (w.operation[OP_POP_BIT]) begin
      if (queued_ids_q.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.result_id = queued_ids_q.pop_front();
        res.status = ST_POPPED;
      end
    end else if (w.operation == OP_REMOVE) begin
      if (idx >= 0) begin
        queued_ids_q.delete(idx);
        res.position = PosW'(idx);
        res.status = ST_REMOVED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else begin
      if (idx >= 0) begin
        res.position = PosW'(idx);
        res.status = ST_ALREADY;
      end else if (queued_ids_q.size() >= QueueDepthDef) begin
        res.status = ST_FULL;
      end else begin
        res.position = PosW'(queued_ids_q.size());
        queued_ids_q.push_back(id);
        res.status = ST_APPENDED;
      end
    end
    res.entry_count = CountW'(queued_ids_q.size());
    return res;
  endfunction

  // Sends one word, honoring the sender idle rate, and records its prediction.
  task automatic send_word(input logic [OpW-1:0] op, input logic [IdFieldW-1:0] id);
    in_word_t w;
    w.operation = op;
    w.vehicle_id = id;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_words.push_back(apply_queue_op(w));
    words_sent++;
  endtask

  // Pops until the predicted queue is empty.
  task automatic drain_queue();
    while (queued_ids_q.size() > 0) send_word(OP_POP, 16'(words_sent));
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
               exp_v, act_v);
    end
  endtask

  // Compare every accepted output word with the oldest prediction.
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, expected none, actual 0x%0h", $time, out_word_o);
      end else begin
        exp_w = pending_words.pop_front();
        report_field("status", exp_w.status, out_word_o.status);
        report_field("result_id", exp_w.result_id, out_word_o.result_id);
        report_field("position", exp_w.position, out_word_o.position);
        report_field("entry_count", exp_w.entry_count, out_word_o.entry_count);
        status_seen[exp_w.status]++;
        words_checked++;
      end
    end
  end

  // Empty queue cases, id extremes, duplicates, and the full queue.
  task automatic test_directed_cases();
    send_word(OP_POP, 16'hA5A5);
    send_word(OP_POP_ALT, 16'h5A5A);
    send_word(OP_REMOVE, 16'h1234);
    send_word(OP_ENTER, 16'h0000);
    send_word(OP_ENTER, 16'hFFFF);
    send_word(OP_ENTER, 16'hFFFF);
    for (int i = 0; i < QueueDepthDef - 2; i++) begin
      send_word(OP_ENTER, 16'(16'h1000 + i * 16'h0111));
    end
    send_word(OP_ENTER, 16'hBEEF);
    send_word(OP_ENTER, 16'(16'h1000 + (QueueDepthDef - 3) * 16'h0111));
    send_word(OP_REMOVE, 16'(16'h1000 + 5 * 16'h0111));
    send_word(OP_REMOVE, 16'h0000);
    send_word(OP_POP, 16'h0000);
    send_word(OP_POP_ALT, 16'hFFFF);
    drain_queue();
  endtask

  function automatic logic [IdFieldW-1:0] pick_id();
    if ($urandom_range(99) < 75) return id_pool[$urandom_range(POOL_SIZE - 1)];
    return IdFieldW'($urandom_range(16'hFFFF));
  endfunction

  // Random traffic over a small id pool so hits are common; fill-heavy and
  // drain-heavy stretches alternate to sweep the entry count.
  task automatic test_random_traffic(input int count);
    int enter_w;
    int r;
    for (int i = 0; i < count; i++) begin
      enter_w = ((i / 50) % 2 == 0) ? 70 : 25;
      r = $urandom_range(99);
      if (r < enter_w) begin
        send_word(OP_ENTER, pick_id());
      end else if ($urandom_range(1) == 0) begin
        send_word(OP_REMOVE, pick_id());
      end else begin
        send_word($urandom_range(1) ? OP_POP_ALT : OP_POP,
                  IdFieldW'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  initial begin
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = IdFieldW'($urandom_range(16'hFFFF));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_directed_cases();
    test_random_traffic(250);
    set_idling(45, 0);
    test_random_traffic(200);
    set_idling(0, 45);
    test_random_traffic(200);
    set_idling(29, 29);
    test_random_traffic(200);
    in_valid_i <= 1'b0;

    while (pending_words.size() > 0) @(posedge clk_i);
    repeat (QueueDepthDef + 8) @(posedge clk_i);

    $display("Sent %0d words, checked %0d results over four idling phases.",
             words_sent, words_checked);
    $display({"Statuses: appended %0d, already %0d, removed %0d, not found %0d, ",
              "popped %0d, empty %0d, full %0d."},
             status_seen[ST_APPENDED], status_seen[ST_ALREADY], status_seen[ST_REMOVED],
             status_seen[ST_NOT_FOUND], status_seen[ST_POPPED], status_seen[ST_EMPTY],
             status_seen[ST_FULL]);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", pending_words.size());
    $display("FAILURE");
    $finish;
  end

endmodule
